// ===== src/integer_alu_with_adjusted_division_macros.svh =====
// Assertion macros used by the checker file of the integer ALU.
`ifndef INTEGER_ALU_WITH_ADJUSTED_DIVISION_MACROS_SVH
`define INTEGER_ALU_WITH_ADJUSTED_DIVISION_MACROS_SVH

// Implication checked only while reset is low.
`define IADIV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked at every clock edge, reset included.
`define IADIV_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/iadiv_pkg.sv =====
// Package with the types and constants of the integer ALU with adjusted division.
package iadiv_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned NumCells = DataW;

  typedef logic [DataW-1:0] word_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_DIV_ZERO = 1'b1
  } status_t;

  typedef struct packed {
    op_t   op;
    logic  a_neg;
    logic  c_neg;
    logic  div_zero;
    word_t divisor;
    word_t mag_c;
    word_t part_rem;
    word_t work;
  } stage_t;

endpackage

// ===== src/iadiv_ifs.sv =====
// Valid/ready channel interfaces for operands and results of the integer ALU.
interface iadiv_in_if;
  import iadiv_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_c;
  op_t                func;

  modport source (output valid, output operand_a, output operand_c, output func,
                  input ready);
  modport sink (input valid, input operand_a, input operand_c, input func,
                output ready);
endinterface

interface iadiv_out_if;
  import iadiv_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic signed [31:0] remainder_value;
  status_t            status;

  modport source (output valid, output result_value, output remainder_value,
                  output status, input ready);
  modport sink (input valid, input result_value, input remainder_value,
                input status, output ready);
endinterface

// ===== src/iadiv_prep.sv =====
// Entry stage: computes add, subtract and multiply, and sets up the divider operands.
module iadiv_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  iadiv_in_if.sink         in_ch,
  output logic             valid,
  output iadiv_pkg::stage_t stage
);
  import iadiv_pkg::*;

  logic   load;
  word_t  a_u;
  word_t  c_u;
  stage_t stage_next;

  assign load        = en || !valid;
  assign in_ch.ready = load;
  assign a_u         = word_t'(in_ch.operand_a);
  assign c_u         = word_t'(in_ch.operand_c);

  always_comb begin
    stage_next          = '0;
    stage_next.op       = in_ch.func;
    stage_next.a_neg    = a_u[DataW-1];
    stage_next.c_neg    = c_u[DataW-1];
    stage_next.div_zero = (c_u == '0);
    stage_next.divisor  = c_u;
    case (in_ch.func)
      OP_ADD: begin
        stage_next.work = a_u + c_u;
      end
      OP_SUB: begin
        stage_next.work = a_u - c_u;
      end
      OP_MUL: begin
        stage_next.work = a_u * c_u;
      end
      OP_DIV: begin
        stage_next.work  = a_u[DataW-1] ? word_t'(-a_u) : a_u;
        stage_next.mag_c = c_u[DataW-1] ? word_t'(-c_u) : c_u;
      end
      default: begin
        stage_next.work = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_ch.valid;
    end
    if (load && in_ch.valid) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== src/iadiv_cell.sv =====
// Divider cell: one restoring step, producing one quotient bit per transaction.
module iadiv_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  iadiv_pkg::stage_t stage_in,
  output logic              valid,
  output iadiv_pkg::stage_t stage
);
  import iadiv_pkg::*;

  logic [DataW:0] trial;
  logic [DataW:0] diff;
  logic           take;
  stage_t         stage_next;

  assign trial = {stage_in.part_rem, stage_in.work[DataW-1]};
  assign diff  = trial - {1'b0, stage_in.mag_c};
  assign take  = !diff[DataW];

  always_comb begin
    stage_next = stage_in;
    if (stage_in.op == OP_DIV) begin
      stage_next.part_rem = take ? diff[DataW-1:0] : trial[DataW-1:0];
      stage_next.work     = {stage_in.work[DataW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== src/iadiv_post.sv =====
// Exit stage: applies signs and the quotient adjustment, and holds the output register.
module iadiv_post (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  iadiv_pkg::stage_t stage_in,
  output logic              en,
  iadiv_out_if.source       out_ch
);
  import iadiv_pkg::*;

  logic    valid;
  word_t   result;
  word_t   remainder;
  status_t status;
  word_t   result_next;
  word_t   remainder_next;
  status_t status_next;
  word_t   mq;
  word_t   mr;
  logic    q_neg;
  logic    fix;

  assign en    = !valid || out_ch.ready;
  assign mq    = stage_in.work;
  assign mr    = stage_in.part_rem;
  assign q_neg = stage_in.a_neg ^ stage_in.c_neg;
  assign fix   = stage_in.a_neg && (mr != '0);

  always_comb begin
    result_next    = stage_in.work;
    remainder_next = '0;
    status_next    = ST_OK;
    if (stage_in.op == OP_DIV) begin
      if (stage_in.div_zero) begin
        result_next = '0;
        status_next = ST_DIV_ZERO;
      end else if (fix) begin
        // The adjusted quotient is one below the truncated one.
        result_next    = q_neg ? ~mq : mq - word_t'(1);
        remainder_next = stage_in.divisor - mr;
      end else begin
        result_next    = q_neg ? word_t'(-mq) : mq;
        remainder_next = stage_in.a_neg ? word_t'(-mr) : mr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      result    <= result_next;
      remainder <= remainder_next;
      status    <= status_next;
    end
  end

  assign out_ch.valid           = valid;
  assign out_ch.result_value    = result;
  assign out_ch.remainder_value = remainder;
  assign out_ch.status          = status;

endmodule

// ===== src/integer_alu_with_adjusted_division.sv =====
// Throughput: one transaction per cycle for every operation, except while the output
// register is stalled. All operations pass through the row of 32 divider cells, one
// quotient bit per cell, between the entry stage and the exit stage.
// Reset clears the valid bits of all stages; the pipeline payload is not reset.
module integer_alu_with_adjusted_division (
  input  logic        clk,
  input  logic        rst,
  iadiv_in_if.sink    in_ch,
  iadiv_out_if.source out_ch
);
  import iadiv_pkg::*;

  logic   en;
  logic   valid [0:NumCells];
  stage_t stage [0:NumCells];

  iadiv_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_ch (in_ch),
    .valid (valid[0]),
    .stage (stage[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    iadiv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (valid[i]),
      .stage_in (stage[i]),
      .valid    (valid[i+1]),
      .stage    (stage[i+1])
    );
  end

  iadiv_post u_post (
    .clk      (clk),
    .rst      (rst),
    .valid_in (valid[NumCells]),
    .stage_in (stage[NumCells]),
    .en       (en),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/iadiv_checker.sv =====
// Port-level checker for the integer ALU, bound to the top level.
`include "integer_alu_with_adjusted_division_macros.svh"

module iadiv_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input iadiv_pkg::word_t out_result,
  input iadiv_pkg::word_t out_remainder,
  input logic             out_status
);

  `IADIV_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst), !out_valid, "Result valid right after reset")

  `IADIV_ASSERT_IMP(a_stall_hold, clk, rst, out_valid && !out_ready, ##1 (out_valid && $stable(out_result) && $stable(out_remainder) && $stable(out_status)), "Stalled result changed")

  `IADIV_ASSERT_IMP(a_zero_on_err, clk, rst, out_valid && out_status, (out_result == '0) && (out_remainder == '0), "Division by zero with nonzero fields")

  `IADIV_ASSERT_IMP(a_ready_only_stall, clk, rst, !in_ready, out_valid && !out_ready, "Input blocked without an output stall")

endmodule

bind integer_alu_with_adjusted_division iadiv_checker u_iadiv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_result    (out_ch.result_value),
  .out_remainder (out_ch.remainder_value),
  .out_status    (out_ch.status)
);

// ===== tb/integer_alu_with_adjusted_division_tb.sv =====
// Self-checking testbench for the integer ALU with adjusted division.
`timescale 1ns / 100ps

module integer_alu_with_adjusted_division_tb;
  import iadiv_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumDirected = 23;
  localparam word_t       MinWord     = 32'h8000_0000;
  localparam word_t       MaxWord     = 32'h7fff_ffff;
  localparam word_t       AllOnes     = 32'hffff_ffff;

  typedef struct packed {
    word_t   res;
    word_t   rem;
    status_t st;
  } alu_result_t;

  typedef struct packed {
    word_t       a;
    word_t       c;
    op_t         op;
    logic        typed;
    alu_result_t want;
  } directed_row_t;

  localparam alu_result_t NoWant = '{res: '0, rem: '0, st: ST_OK};

  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{MaxWord, 32'd1, OP_ADD, 1'b1, '{MinWord, '0, ST_OK}},
    '{MinWord, MinWord, OP_ADD, 1'b1, '{32'd0, '0, ST_OK}},
    '{32'd0, 32'd0, OP_ADD, 1'b1, '{32'd0, '0, ST_OK}},
    '{MinWord, 32'd1, OP_SUB, 1'b1, '{MaxWord, '0, ST_OK}},
    '{32'd0, MinWord, OP_SUB, 1'b1, '{MinWord, '0, ST_OK}},
    '{MaxWord, MaxWord, OP_MUL, 1'b1, '{32'd1, '0, ST_OK}},
    '{MinWord, AllOnes, OP_MUL, 1'b1, '{MinWord, '0, ST_OK}},
    '{AllOnes, AllOnes, OP_MUL, 1'b1, '{32'd1, '0, ST_OK}},
    '{32'd5, 32'd0, OP_DIV, 1'b1, '{32'd0, '0, ST_DIV_ZERO}},
    '{MinWord, 32'd0, OP_DIV, 1'b1, '{32'd0, '0, ST_DIV_ZERO}},
    '{32'd0, 32'd0, OP_DIV, 1'b1, '{32'd0, '0, ST_DIV_ZERO}},
    '{MinWord, AllOnes, OP_DIV, 1'b1, '{MinWord, '0, ST_OK}},
    '{-32'sd7, -32'sd2, OP_DIV, 1'b1, '{32'd2, -32'sd3, ST_OK}},
    '{-32'sd7, 32'd2, OP_DIV, 1'b1, '{-32'sd4, 32'd1, ST_OK}},
    '{32'd7, -32'sd2, OP_DIV, 1'b1, '{-32'sd3, 32'd1, ST_OK}},
    '{32'd7, 32'd2, OP_DIV, 1'b1, '{32'd3, 32'd1, ST_OK}},
    '{-32'sd8, 32'd2, OP_DIV, 1'b1, '{-32'sd4, 32'd0, ST_OK}},
    '{MinWord, 32'd1, OP_DIV, 1'b1, '{MinWord, 32'd0, ST_OK}},
    '{MinWord, MaxWord, OP_DIV, 1'b0, NoWant},
    '{MaxWord, MinWord, OP_DIV, 1'b0, NoWant},
    '{AllOnes, MinWord, OP_DIV, 1'b0, NoWant},
    '{MaxWord, AllOnes, OP_DIV, 1'b0, NoWant},
    '{AllOnes, MaxWord, OP_DIV, 1'b0, NoWant}
  };

  logic clk = 1'b0;
  logic rst;

  iadiv_in_if  in_ch ();
  iadiv_out_if out_ch ();

  integer_alu_with_adjusted_division dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_result_t pending_results [$];
  alu_result_t arrived_want;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned directed_sent;
  int unsigned random_sent;
  int unsigned zero_divides;
  int unsigned cycle_count;

  always #5 clk = ~clk;

  function automatic alu_result_t alu_outcome(word_t a, word_t c, op_t op);
    alu_result_t r;
    word_t       mag_a;
    word_t       mag_c;
    word_t       trunc_q;
    word_t       trunc_r;
    r.res = '0;
    r.rem = '0;
    r.st  = ST_OK;
    case (op)
      OP_ADD: r.res = a + c;
      OP_SUB: r.res = a - c;
      OP_MUL: r.res = a * c;
      default: begin
        if (c == '0) begin
          r.st = ST_DIV_ZERO;
        end else begin
          mag_a   = a[31] ? -a : a;
          mag_c   = c[31] ? -c : c;
          trunc_q = mag_a / mag_c;
          if (a[31] ^ c[31]) begin
            trunc_q = -trunc_q;
          end
          trunc_r = a - trunc_q * c;
          // A negative dividend with a nonzero remainder rounds the quotient down.
          if (a[31] && trunc_r != '0) begin
            r.res = trunc_q - 32'd1;
            r.rem = a - r.res * c;
          end else begin
            r.res = trunc_q;
            r.rem = trunc_r;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic word_t pick_operand();
    word_t w;
    case ($urandom_range(0, 7))
      0, 1, 2: w = $urandom;
      3, 4: w = $urandom_range(0, 64) - 32;
      5: begin
        case ($urandom_range(0, 4))
          0: w = MinWord;
          1: w = MaxWord;
          2: w = AllOnes;
          3: w = 32'd1;
          default: w = 32'd0;
        endcase
      end
      6: w = $urandom_range(0, 65535) - 32768;
      default: w = {1'b1, 31'($urandom)};
    endcase
    return w;
  endfunction

  task automatic check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_op(word_t a, word_t c, op_t op, alu_result_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= a;
    in_ch.operand_c <= c;
    in_ch.func      <= op;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_results.push_back(want);
    if (want.st == ST_DIV_ZERO) begin
      zero_divides++;
    end
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic send_random(int unsigned count);
    word_t a;
    word_t c;
    op_t   op;
    repeat (count) begin
      a  = pick_operand();
      c  = pick_operand();
      op = op_t'($urandom_range(0, 3));
      send_op(a, c, op, alu_outcome(a, c, op));
      random_sent++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h %h %0d", $time,
                 out_ch.result_value, out_ch.remainder_value, out_ch.status);
        mismatches++;
      end else begin
        arrived_want = pending_results.pop_front();
        check_field("result_value", arrived_want.res, out_ch.result_value);
        check_field("remainder_value", arrived_want.rem, out_ch.remainder_value);
        check_field("status", {31'd0, arrived_want.st}, {31'd0, out_ch.status});
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d transactions outstanding", $time,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.operand_a = '0;
    in_ch.operand_c = '0;
    in_ch.func      = OP_ADD;
    out_ch.ready    = 1'b0;
    send_gap_pct    = 26;
    recv_stall_pct  = 65;
    mismatches      = 0;
    results_checked = 0;
    directed_sent   = 0;
    random_sent     = 0;
    zero_divides    = 0;
    cycle_count     = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DirectedRows[i]) begin
      send_op(DirectedRows[i].a, DirectedRows[i].c, DirectedRows[i].op,
              DirectedRows[i].typed ? DirectedRows[i].want :
              alu_outcome(DirectedRows[i].a, DirectedRows[i].c, DirectedRows[i].op));
      directed_sent++;
    end
    drain_pipeline();

    send_random(620);
    send_gap_pct   = 65;
    recv_stall_pct = 26;
    send_random(620);
    drain_pipeline();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_random(610);

    drain_pipeline();
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d directed and %0d random operations, %0d of them divisions by zero.",
             directed_sent, random_sent, zero_divides);
    $display("Checked %0d results under three patterns of sender gaps and receiver stalls.",
             results_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
